>>> sv/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check on clk, masked while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check on clk, also live during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/ibad_pkg.sv
// Types and codes of the interrupt bit allocator and dispatcher.
package ibad_pkg;

  localparam int CMD_W = 3;
  localparam int IDX_W = 6;
  localparam int TGT_W = 2;
  localparam int PEND_W = 32;
  localparam int BIT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC_TH = 3'd0,
    CMD_FREE_TH  = 3'd1,
    CMD_ALLOC_FH = 3'd2,
    CMD_FREE_FH  = 3'd3,
    CMD_DISPATCH = 3'd4
  } cmd_t;

  localparam logic [TGT_W-1:0] TGT_FIRST  = 2'd0;
  localparam logic [TGT_W-1:0] TGT_SECOND = 2'd1;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

endpackage

>>> sv/ibad_cmd_if.sv
// Command channel: valid/ready handshake with the command word.
interface ibad_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [ibad_pkg::CMD_W-1:0]  cmd;
  logic [ibad_pkg::IDX_W-1:0]  bit_index;
  logic [ibad_pkg::TGT_W-1:0]  target;
  logic [ibad_pkg::PEND_W-1:0] pending;

  modport source (output valid, output cmd, output bit_index, output target,
                  output pending, input ready);
  modport sink (input valid, input cmd, input bit_index, input target,
                input pending, output ready);
endinterface

>>> sv/ibad_res_if.sv
// Result channel: valid/ready handshake with the result word.
interface ibad_res_if;
  logic                      valid;
  logic                      ready;
  logic                      status;
  logic [ibad_pkg::BIT_W-1:0] bit_out;
  logic                      last;

  modport source (output valid, output status, output bit_out, output last,
                  input ready);
  modport sink (input valid, input status, input bit_out, input last,
                output ready);
endinterface

>>> sv/ibad_ffs.sv
// Shared find-first-set unit: lowest set bit of a word, one-hot and index.
module ibad_ffs #(
  parameter int W = 32
) (
  input  logic [W-1:0]               word,
  output logic                       found,
  output logic [W-1:0]               onehot,
  output logic [ibad_pkg::BIT_W-1:0] idx
);
  import ibad_pkg::*;

  assign found  = (word != '0);
  // two's complement trick isolates the lowest set bit
  assign onehot = word & (~word + W'(1));

  always_comb begin
    logic [BIT_W-1:0] iv;
    idx = '0;
    for (int i = 0; i < W; i++) begin
      iv = BIT_W'(i);
      for (int b = 0; b < BIT_W; b++) begin
        if (iv[b]) idx[b] = idx[b] | onehot[i];
      end
    end
  end

endmodule

>>> sv/interrupt_bit_allocator_dispatch_core.sv
// Top level: interrupt bit allocator and dispatcher with its sequencer.
//
// Usage:
//   req carries one command word (cmd, bit_index, target, pending); rsp
//   carries result words (status, bit_out, last). Both are valid/ready.
//   Alloc, free and unknown commands give one result word with last set.
//   Dispatch gives one word per pending bit that is allocated in the
//   to-host map, lowest first, last on the highest; none if there is none.
// Timing:
//   req.ready is high while the sequencer is idle. A command is taken into
//   the run registers, and its result is loaded into the output register
//   once that register is empty or rsp.ready is high; a dispatch loads one
//   word per hit. The rate is set by the one shared find-first-set unit,
//   which yields one bit per cycle while no result word is stalled.
// Reset (rst, synchronous): all three maps clear, no result pending.
// Stall: a waiting result word does not block the next command; while it
//   waits and rsp.ready is low the sequencer holds and emits nothing further.
module interrupt_bit_allocator_dispatch_core #(
  parameter int NUM_BITS = 32
) (
  input logic      clk,
  input logic      rst,
  ibad_cmd_if.sink  req,
  ibad_res_if.source rsp
);
  import ibad_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t              state;
  logic [CMD_W-1:0]    run_cmd;
  logic [IDX_W-1:0]    run_idx;
  logic [TGT_W-1:0]    run_tgt;
  logic [NUM_BITS-1:0] hits;
  logic [NUM_BITS-1:0] tohost_map, fh_first_map, fh_second_map;

  logic                out_valid, out_status, out_last;
  logic [BIT_W-1:0]    out_bit;

  logic [NUM_BITS-1:0] cur_map, ffs_word, ffs_onehot, free_mask;
  logic                ffs_found;
  logic [BIT_W-1:0]    ffs_idx;
  logic                tgt_ok, idx_ok, load;
  logic                res_emit, res_status, res_last;
  logic [BIT_W-1:0]    res_bit;

  assign req.ready   = (state == S_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.status  = out_status;
  assign rsp.bit_out = out_bit;
  assign rsp.last    = out_last;

  assign tgt_ok    = (run_tgt == TGT_FIRST) || (run_tgt == TGT_SECOND);
  assign idx_ok    = (run_idx < IDX_W'(NUM_BITS));
  assign free_mask = NUM_BITS'(1) << run_idx;
  assign load      = (state == S_RUN) && (!out_valid || rsp.ready);

  always_comb begin
    cur_map = tohost_map;
    if (run_cmd == CMD_ALLOC_FH) begin
      cur_map = (run_tgt == TGT_SECOND) ? fh_second_map : fh_first_map;
    end
  end

  assign ffs_word = (run_cmd == CMD_DISPATCH) ? hits : ~cur_map;

  ibad_ffs #(.W(NUM_BITS)) u_ffs (
    .word   (ffs_word),
    .found  (ffs_found),
    .onehot (ffs_onehot),
    .idx    (ffs_idx)
  );

  always_comb begin
    res_emit   = 1'b1;
    res_status = ST_ERR;
    res_bit    = '0;
    res_last   = 1'b1;
    unique case (run_cmd)
      CMD_ALLOC_TH: begin
        res_status = ffs_found ? ST_OK : ST_ERR;
        res_bit    = ffs_found ? ffs_idx : '0;
      end
      CMD_FREE_TH: res_status = idx_ok ? ST_OK : ST_ERR;
      CMD_ALLOC_FH: begin
        res_status = (tgt_ok && ffs_found) ? ST_OK : ST_ERR;
        res_bit    = (tgt_ok && ffs_found) ? ffs_idx : '0;
      end
      CMD_FREE_FH: res_status = (idx_ok && tgt_ok) ? ST_OK : ST_ERR;
      CMD_DISPATCH: begin
        res_emit   = ffs_found;
        res_status = ST_OK;
        res_bit    = ffs_idx;
        res_last   = ((hits & ~ffs_onehot) == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      tohost_map    <= '0;
      fh_first_map  <= '0;
      fh_second_map <= '0;
    end else begin
      if (load && res_emit) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            run_cmd <= req.cmd;
            run_idx <= req.bit_index;
            run_tgt <= req.target;
            hits    <= req.pending[NUM_BITS-1:0] & tohost_map;
            state   <= S_RUN;
          end
        end
        S_RUN: begin
          if (load) begin
            if (res_emit) begin
              out_status <= res_status;
              out_bit    <= res_bit;
              out_last   <= res_last;
            end
            unique case (run_cmd)
              CMD_ALLOC_TH: if (ffs_found) tohost_map <= tohost_map | ffs_onehot;
              CMD_FREE_TH:  if (idx_ok) tohost_map <= tohost_map & ~free_mask;
              CMD_ALLOC_FH: begin
                if (ffs_found && run_tgt == TGT_FIRST) begin
                  fh_first_map <= fh_first_map | ffs_onehot;
                end
                if (ffs_found && run_tgt == TGT_SECOND) begin
                  fh_second_map <= fh_second_map | ffs_onehot;
                end
              end
              CMD_FREE_FH: begin
                if (idx_ok && run_tgt == TGT_FIRST) begin
                  fh_first_map <= fh_first_map & ~free_mask;
                end
                if (idx_ok && run_tgt == TGT_SECOND) begin
                  fh_second_map <= fh_second_map & ~free_mask;
                end
              end
              CMD_DISPATCH: hits <= hits & ~ffs_onehot;
              default: ;
            endcase
            if (run_cmd != CMD_DISPATCH || !res_emit || res_last) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "assert_macros.svh"

  // each dispatch step retires exactly one hit
  `ASSERT_CLK(a_hits_step, (load && run_cmd == CMD_DISPATCH && ffs_found) |=> ($countones(hits) + 1 == $past($countones(hits))), "dispatch step did not retire one hit")

  // the word marked last ends the command
  `ASSERT_CLK(a_last_ends, (load && res_emit && res_last) |=> (state == S_IDLE), "sequencer busy after last word")

  // a successful to-host allocation marks the chosen bit
  `ASSERT_CLK(a_alloc_marks, (load && run_cmd == CMD_ALLOC_TH && ffs_found) |=> ((tohost_map & $past(ffs_onehot)) != '0), "allocated bit not marked")

  // reset leaves no result word pending
  `ASSERT_ALWAYS(a_reset_clear, $past(rst) |-> !out_valid, "result valid after reset")

endmodule
